@@ hdl/ifcs_pkg.sv @@
`default_nettype none

package ifcs_pkg;

  // default configuration of the core
  localparam int unsigned INJECTOR_CHANNELS_DEF = 4;
  localparam int unsigned COUNT_WIDTH_DEF       = 16;

  // register map: timing registers first, then the four filter registers
  localparam int unsigned CFG_INDEX_W   = 4;
  localparam int unsigned CFG_DATA_W    = 48;
  localparam int unsigned TIMING_FLD_W  = 16;
  localparam int unsigned FILTER_REGS   = 4;
  localparam int unsigned REG_START_DLY = 0;
  localparam int unsigned REG_ON_TIME   = 1;
  localparam int unsigned REG_GAP_DLY   = 2;
  localparam int unsigned REG_REPEAT    = 3;

  // stream widths
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned OUT_FLDS_W  = 14;
  localparam int unsigned OUT_CH_W    = 4;
  localparam int unsigned FILTERS     = 3;

  // result queue
  localparam int unsigned OUT_DEPTH   = 4;
  localparam int unsigned OUT_PTR_W   = 2;
  localparam int unsigned OUT_CNT_W   = 3;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_RESTART = 2'd1,
    OP_START   = 2'd2,
    OP_STOP    = 2'd3
  } opcode_e;

  // filtration steps
  localparam logic [2:0] STEP_IDLE  = 3'd0;
  localparam logic [2:0] STEP_FIRST = 3'd1;
  localparam logic [2:0] STEP_GAP_A = 3'd3;
  localparam logic [2:0] STEP_GAP_B = 3'd5;
  localparam logic [2:0] STEP_LAST  = 3'd7;

  // filter bit that turns on when leaving a wait step
  function automatic logic [2:0] filter_turn_on(input logic [2:0] step);
    logic [2:0] res;
    case (step)
      STEP_FIRST: res = 3'b001;
      STEP_GAP_A: res = 3'b010;
      STEP_GAP_B: res = 3'b100;
      default:    res = 3'b000;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

@@ hdl/ifcs_ram.sv @@
`default_nettype none

module ifcs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                      wdata_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // read-first, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ hdl/injector_and_filter_cycle_sequencer_core.sv @@
`default_nettype none
// a taken beat is swept over every channel, then its result goes into the result queue
// the next beat is taken as the last channel of the previous one is read, if a credit is
//   free; the sweep uses the single read and write port of the channel state memory
// reset: rst_ni clears control, valid bits, filter sequencer and registers at once;
//   the memories get no clearing pass, an entry never written reads as zero

module injector_and_filter_cycle_sequencer_core #(
  parameter int unsigned INJECTOR_CHANNELS = ifcs_pkg::INJECTOR_CHANNELS_DEF,
  parameter int unsigned COUNT_WIDTH       = ifcs_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration write channel
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [ifcs_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  wire logic [ifcs_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // input stream
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [ifcs_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [0] fertigation_enable
  input  wire logic [ifcs_pkg::IN_TUSER_W-1:0]    s_axis_tuser,  // [1:0] opcode
  // result stream
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [3:0] injector_outputs, [6:4] filter_outputs, [9:7] filter_step, [13:10] injectors_done
  output logic      [ifcs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  localparam int unsigned ChW  = (INJECTOR_CHANNELS > 1) ? $clog2(INJECTOR_CHANNELS) : 1;
  localparam int unsigned CntW = COUNT_WIDTH;
  localparam int unsigned FldW = (CntW < ifcs_pkg::TIMING_FLD_W) ? CntW
                                                                 : ifcs_pkg::TIMING_FLD_W;
  localparam int unsigned AccW = (INJECTOR_CHANNELS > ifcs_pkg::OUT_CH_W) ? INJECTOR_CHANNELS
                                                                          : ifcs_pkg::OUT_CH_W;
  // channel state word: on bit, on count, off count, cycles done
  localparam int unsigned StW  = 1 + 3 * CntW;
  // timing word: on period, off period, cycle count
  localparam int unsigned TmW  = 3 * CntW;
  localparam logic [ChW-1:0] LastCh = ChW'(INJECTOR_CHANNELS - 1);
  localparam logic [ifcs_pkg::CFG_INDEX_W-1:0] IdxStart =
    ifcs_pkg::CFG_INDEX_W'(INJECTOR_CHANNELS + ifcs_pkg::REG_START_DLY);
  localparam logic [ifcs_pkg::CFG_INDEX_W-1:0] IdxOnTime =
    ifcs_pkg::CFG_INDEX_W'(INJECTOR_CHANNELS + ifcs_pkg::REG_ON_TIME);
  localparam logic [ifcs_pkg::CFG_INDEX_W-1:0] IdxGap =
    ifcs_pkg::CFG_INDEX_W'(INJECTOR_CHANNELS + ifcs_pkg::REG_GAP_DLY);
  localparam logic [ifcs_pkg::CFG_INDEX_W-1:0] IdxRepeat =
    ifcs_pkg::CFG_INDEX_W'(INJECTOR_CHANNELS + ifcs_pkg::REG_REPEAT);
  localparam logic [ifcs_pkg::CFG_INDEX_W-1:0] IdxChans =
    ifcs_pkg::CFG_INDEX_W'(INJECTOR_CHANNELS);

  // ---------------------------------------------------------------------------
  // configuration: timing words go to the timing memory, filter delays to flops
  // ---------------------------------------------------------------------------
  logic cfg_fire;
  logic tm_we;
  logic [TmW-1:0] tm_wdata;
  logic [CntW-1:0] start_dly_q, on_time_q, gap_dly_q, repeat_dly_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;
  assign tm_we       = cfg_fire && (cfg_index_i < IdxChans);
  // each 16 bit field is cut or widened to the counter width
  assign tm_wdata = {CntW'(cfg_data_i[32 +: FldW]),
                     CntW'(cfg_data_i[16 +: FldW]),
                     CntW'(cfg_data_i[0 +: FldW])};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_dly_q  <= '0;
      on_time_q    <= '0;
      gap_dly_q    <= '0;
      repeat_dly_q <= '0;
    end else if (cfg_fire) begin
      if (cfg_index_i == IdxStart)  start_dly_q  <= CntW'(cfg_data_i[0 +: FldW]);
      if (cfg_index_i == IdxOnTime) on_time_q    <= CntW'(cfg_data_i[0 +: FldW]);
      if (cfg_index_i == IdxGap)    gap_dly_q    <= CntW'(cfg_data_i[0 +: FldW]);
      if (cfg_index_i == IdxRepeat) repeat_dly_q <= CntW'(cfg_data_i[0 +: FldW]);
    end
  end

  // ---------------------------------------------------------------------------
  // admission: credits cover the pipeline plus the result queue
  // ---------------------------------------------------------------------------
  logic in_fire, out_fire;
  logic [ifcs_pkg::OUT_CNT_W-1:0] pend_q, pend_d;
  logic iss_valid_q, iss_valid_d;
  logic [ChW-1:0] iss_ch_q, iss_ch_d;
  ifcs_pkg::opcode_e iss_op_q;
  logic iss_fert_q;
  logic [2:0] iss_fout_q, iss_fstep_q;
  logic iss_last;
  ifcs_pkg::opcode_e in_op;

  assign in_op    = ifcs_pkg::opcode_e'(s_axis_tuser[1:0]);
  assign iss_last = iss_valid_q && (iss_ch_q == LastCh);
  // taken when idle or on the last channel of the previous beat, with a free credit
  assign s_axis_tready = (!iss_valid_q || iss_last) &&
                         (pend_q != ifcs_pkg::OUT_CNT_W'(ifcs_pkg::OUT_DEPTH));
  assign in_fire  = s_axis_tvalid & s_axis_tready;
  assign out_fire = m_axis_tvalid & m_axis_tready;

  always_comb begin
    pend_d = pend_q;
    if (in_fire && !out_fire) begin
      pend_d = pend_q + ifcs_pkg::OUT_CNT_W'(1);
    end else if (!in_fire && out_fire) begin
      pend_d = pend_q - ifcs_pkg::OUT_CNT_W'(1);
    end
  end

  always_comb begin
    iss_valid_d = iss_valid_q;
    iss_ch_d    = iss_ch_q;
    if (in_fire) begin
      iss_valid_d = 1'b1;
      iss_ch_d    = '0;
    end else if (iss_valid_q) begin
      if (iss_last) begin
        iss_valid_d = 1'b0;
      end else begin
        iss_ch_d = iss_ch_q + ChW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // filtration sequencer: one update per beat, done at admission
  // ---------------------------------------------------------------------------
  logic [2:0] f_step_q, f_step_d;
  logic [2:0] f_on_q, f_on_d;
  logic [CntW-1:0] f_ticks_q, f_ticks_d, f_ticks_inc, f_target;

  assign f_ticks_inc = f_ticks_q + CntW'(1);

  always_comb begin
    case (f_step_q)
      ifcs_pkg::STEP_FIRST: f_target = start_dly_q;
      ifcs_pkg::STEP_GAP_A: f_target = gap_dly_q;
      ifcs_pkg::STEP_GAP_B: f_target = gap_dly_q;
      ifcs_pkg::STEP_LAST:  f_target = repeat_dly_q;
      default:              f_target = on_time_q;
    endcase
  end

  always_comb begin
    f_step_d  = f_step_q;
    f_on_d    = f_on_q;
    f_ticks_d = f_ticks_q;
    case (in_op)
      ifcs_pkg::OP_TICK: begin
        if (f_step_q == ifcs_pkg::STEP_IDLE) begin
          f_ticks_d = '0;
        end else if (f_ticks_inc != f_target) begin
          f_ticks_d = f_ticks_inc;
        end else begin
          f_ticks_d = '0;
          if (f_step_q == ifcs_pkg::STEP_LAST) begin
            f_step_d = ifcs_pkg::STEP_FIRST;
          end else begin
            // odd steps are waits that end with a filter on, even ones end it
            f_on_d   = f_step_q[0] ? (f_on_q | ifcs_pkg::filter_turn_on(f_step_q)) : 3'b000;
            f_step_d = f_step_q + 3'd1;
          end
        end
      end
      ifcs_pkg::OP_START: begin
        f_step_d  = ifcs_pkg::STEP_FIRST;
        f_ticks_d = '0;
        f_on_d    = 3'b000;
      end
      ifcs_pkg::OP_STOP: begin
        f_step_d  = ifcs_pkg::STEP_IDLE;
        f_ticks_d = '0;
        f_on_d    = 3'b000;
      end
      default: begin
        // restart leaves filtration alone
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_step_q  <= ifcs_pkg::STEP_IDLE;
      f_on_q    <= '0;
      f_ticks_q <= '0;
    end else if (in_fire) begin
      f_step_q  <= f_step_d;
      f_on_q    <= f_on_d;
      f_ticks_q <= f_ticks_d;
    end
  end

  // ---------------------------------------------------------------------------
  // channel sweep: read a channel, update it next cycle, write it back
  // ---------------------------------------------------------------------------
  logic [INJECTOR_CHANNELS-1:0] st_vld_q, tm_vld_q;
  logic [StW-1:0] st_rdata, st_wdata;
  logic [TmW-1:0] tm_rdata;
  logic s1_valid_q;
  logic [ChW-1:0] s1_ch_q;

  ifcs_ram #(
    .Width(StW),
    .Depth(INJECTOR_CHANNELS)
  ) u_state_ram (
    .clk_i  (clk_i),
    .we_i   (s1_valid_q),
    .waddr_i(s1_ch_q),
    .wdata_i(st_wdata),
    .raddr_i(iss_ch_q),
    .rdata_o(st_rdata)
  );

  ifcs_ram #(
    .Width(TmW),
    .Depth(INJECTOR_CHANNELS)
  ) u_timing_ram (
    .clk_i  (clk_i),
    .we_i   (tm_we),
    .waddr_i(cfg_index_i[ChW-1:0]),
    .wdata_i(tm_wdata),
    .raddr_i(iss_ch_q),
    .rdata_o(tm_rdata)
  );

  ifcs_pkg::opcode_e s1_op_q;
  logic s1_fert_q, s1_st_vld_q, s1_tm_vld_q;
  logic [2:0] s1_fout_q, s1_fstep_q;
  // write-back of the same channel that is read in the same cycle
  logic fwd_q, fwd_d;
  logic [StW-1:0] fwd_data_q;

  assign fwd_d = s1_valid_q && iss_valid_q && (iss_ch_q == s1_ch_q);

  logic [StW-1:0] cur_st;
  logic [TmW-1:0] cur_tm;
  logic cur_on, new_on;
  logic [CntW-1:0] cur_onc, cur_offc, cur_cyc, new_onc, new_offc, new_cyc;
  logic [CntW-1:0] on_p, off_p, cyc_p;
  logic ch_done;

  always_comb begin
    if (fwd_q) begin
      cur_st = fwd_data_q;
    end else if (s1_st_vld_q) begin
      cur_st = st_rdata;
    end else begin
      cur_st = '0;
    end
    cur_tm   = s1_tm_vld_q ? tm_rdata : '0;
    cur_on   = cur_st[0];
    cur_onc  = cur_st[1 +: CntW];
    cur_offc = cur_st[1 + CntW +: CntW];
    cur_cyc  = cur_st[1 + 2 * CntW +: CntW];
    on_p     = cur_tm[0 +: CntW];
    off_p    = cur_tm[CntW +: CntW];
    cyc_p    = cur_tm[2 * CntW +: CntW];
  end

  always_comb begin
    new_on   = cur_on;
    new_onc  = cur_onc;
    new_offc = cur_offc;
    new_cyc  = cur_cyc;
    case (s1_op_q)
      ifcs_pkg::OP_TICK: begin
        if (s1_fert_q) begin
          if (cur_on) begin
            if (cur_onc == on_p) begin
              new_on   = 1'b0;
              new_onc  = '0;
              new_offc = cur_offc + CntW'(1);
              new_cyc  = cur_cyc + CntW'(1);
            end else begin
              new_onc = cur_onc + CntW'(1);
            end
          end else if (cur_offc == off_p) begin
            // off period over: start another cycle, or hold when none are left
            if (cur_cyc < cyc_p) begin
              new_on   = 1'b1;
              new_onc  = cur_onc + CntW'(1);
              new_offc = '0;
            end
          end else begin
            new_offc = cur_offc + CntW'(1);
          end
        end
      end
      ifcs_pkg::OP_RESTART: begin
        new_on   = 1'b1;
        new_onc  = '0;
        new_offc = '0;
        new_cyc  = '0;
      end
      default: begin
        // filter commands leave the channels alone
      end
    endcase
  end

  assign st_wdata = {new_cyc, new_offc, new_onc, new_on};
  assign ch_done  = !new_on && (new_cyc >= cyc_p) && (new_offc == off_p);

  // per-beat collection of channel status bits
  logic [AccW-1:0] acc_on_q, acc_done_q, acc_on_d, acc_done_d;

  always_comb begin
    acc_on_d   = (s1_ch_q == '0) ? '0 : acc_on_q;
    acc_done_d = (s1_ch_q == '0) ? '0 : acc_done_q;
    acc_on_d[s1_ch_q]   = new_on;
    acc_done_d[s1_ch_q] = ch_done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      iss_valid_q <= 1'b0;
      iss_ch_q    <= '0;
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      st_vld_q    <= '0;
      tm_vld_q    <= '0;
      acc_on_q    <= '0;
      acc_done_q  <= '0;
    end else begin
      pend_q      <= pend_d;
      iss_valid_q <= iss_valid_d;
      iss_ch_q    <= iss_ch_d;
      s1_valid_q  <= iss_valid_q;
      fwd_q       <= fwd_d;
      if (s1_valid_q) begin
        st_vld_q[s1_ch_q] <= 1'b1;
        acc_on_q          <= acc_on_d;
        acc_done_q        <= acc_done_d;
      end
      if (tm_we) begin
        tm_vld_q[cfg_index_i[ChW-1:0]] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      iss_op_q    <= in_op;
      iss_fert_q  <= s_axis_tdata[0];
      iss_fout_q  <= f_on_d;
      iss_fstep_q <= f_step_d;
    end
    s1_ch_q     <= iss_ch_q;
    s1_op_q     <= iss_op_q;
    s1_fert_q   <= iss_fert_q;
    s1_fout_q   <= iss_fout_q;
    s1_fstep_q  <= iss_fstep_q;
    s1_st_vld_q <= st_vld_q[iss_ch_q];
    s1_tm_vld_q <= tm_vld_q[iss_ch_q];
    fwd_data_q  <= st_wdata;
  end

  // ---------------------------------------------------------------------------
  // result queue
  // ---------------------------------------------------------------------------
  logic push;
  logic [ifcs_pkg::OUT_FLDS_W-1:0] push_data;
  logic [ifcs_pkg::OUT_FLDS_W-1:0] fifo_q [ifcs_pkg::OUT_DEPTH];
  logic [ifcs_pkg::OUT_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [ifcs_pkg::OUT_CNT_W-1:0] fifo_cnt_q, fifo_cnt_d;

  assign push      = s1_valid_q && (s1_ch_q == LastCh);
  assign push_data = {acc_done_d[ifcs_pkg::OUT_CH_W-1:0], s1_fstep_q, s1_fout_q,
                      acc_on_d[ifcs_pkg::OUT_CH_W-1:0]};

  always_comb begin
    fifo_cnt_d = fifo_cnt_q;
    if (push && !out_fire) begin
      fifo_cnt_d = fifo_cnt_q + ifcs_pkg::OUT_CNT_W'(1);
    end else if (!push && out_fire) begin
      fifo_cnt_d = fifo_cnt_q - ifcs_pkg::OUT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      fifo_cnt_q <= fifo_cnt_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + ifcs_pkg::OUT_PTR_W'(1);
      end
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + ifcs_pkg::OUT_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= push_data;
    end
  end

  assign m_axis_tvalid = (fifo_cnt_q != '0);
  assign m_axis_tdata  = {{(ifcs_pkg::OUT_TDATA_W - ifcs_pkg::OUT_FLDS_W){1'b0}},
                          fifo_q[rd_ptr_q]};

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_no_queue_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !out_fire |-> fifo_cnt_q != ifcs_pkg::OUT_CNT_W'(ifcs_pkg::OUT_DEPTH))
    else $error("result queue overflow");

  a_credit_covers_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt_q <= pend_q)
    else $error("queued results exceed outstanding beats");

  a_sweep_starts_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> iss_valid_q && iss_ch_q == '0)
    else $error("channel sweep did not restart");

  a_idle_ticks_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_step_q == ifcs_pkg::STEP_IDLE |-> f_ticks_q == '0 && f_on_q == 3'b000)
    else $error("idle filtration with live counter or filter");

  a_one_filter_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(f_on_q))
    else $error("more than one filter on");

endmodule

`default_nettype wire
